// ===== src/zbf_pkg.sv =====
package zbf_pkg;

   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;

   // Field widths sized for the largest supported screen (4096 x 4096).
   localparam int COORD_W = 12;
   localparam int DIM_W   = 13;
   localparam int ADDR_W  = 24;

   localparam int DIV_W     = 25;
   localparam int DEN_W     = 17;
   localparam int DIV_CNT_W = 5;
   localparam int DEPTH_SHIFT = 8;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] ACT_DRAW  = 2'd0;
   localparam logic [1:0] ACT_FRAME = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_MODE   = 2'd2;

   typedef enum logic [2:0] {
      CMD_SPAN,
      CMD_REJECT,
      CMD_FRAME,
      CMD_READ,
      CMD_NOP
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type          op;
      logic [31:0]         d1;
      logic [31:0]         d2;
      logic [31:0]         step;
      logic [15:0]         adv;
      logic [COORD_W-1:0]  x_lo;
      logic [COORD_W-1:0]  x_hi;
      logic [ADDR_W-1:0]   base;
      logic [15:0]         color;
      logic [DIM_W-1:0]    w;
      logic [DIM_W-1:0]    h;
   } cmd_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_DIV,
      F_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_SETUP,
      B_PREP,
      B_SPAN,
      B_DRAIN,
      B_CLEAR,
      B_READ,
      B_RDATA,
      B_RESULT
   } back_state_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [8:0] v, input int maxv);
      logic [DIM_W-1:0] r;
      if (v == 9'd0) begin
         r = DIM_W'(1);
      end else if (int'(v) > maxv) begin
         r = DIM_W'(maxv);
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

endpackage

// ===== src/zbf_if.sv =====
interface zbf_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic signed [15:0] row;
   logic signed [15:0] left_col;
   logic signed [15:0] right_col;
   logic signed [31:0] left_depth;
   logic signed [31:0] right_depth;
   logic [15:0]        fill_color;
   logic [7:0]         read_col;
   logic [7:0]         read_row;

   modport source (output valid, action, row, left_col, right_col, left_depth,
                   right_depth, fill_color, read_col, read_row, input ready);
   modport sink (input valid, action, row, left_col, right_col, left_depth,
                 right_depth, fill_color, read_col, read_row, output ready);
endinterface

interface zbf_rsp_if;
   logic        valid;
   logic        ready;
   logic        span_rejected;
   logic [8:0]  pixels_written;
   logic [15:0] read_color;
   logic [31:0] read_depth;

   modport source (output valid, span_rejected, pixels_written, read_color,
                   read_depth, input ready);
   modport sink (input valid, span_rejected, pixels_written, read_color,
                 read_depth, output ready);
endinterface

// ===== src/zbuffer_solid_span_fill.sv =====
// Span request: the front runs its divider, then pushes the command; the back then sets up,
// prepares and walks the N visible pixels, one pixel per cycle through the depth memory port.
// Read request: the back reads both stores, then answers; rejected spans and no-ops skip the stores.
// A frame request with a zero offset sweeps the depth store, width x height entries.
// The front accepts no request until the last is pushed, which waits while the two-entry queue is full.
// Synchronous reset clears control state, offset and maximum; the stores are not cleared.
module zbuffer_solid_span_fill #(
   parameter int MAX_WIDTH  = zbf_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = zbf_pkg::DEF_MAX_HEIGHT
) (
   input  logic       clock,
   input  logic       reset,
   zbf_req_if.sink    req_bus,
   zbf_rsp_if.source  rsp_bus,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [8:0] csr_wdata
);
   import zbf_pkg::*;

   logic    push, pop, full, empty;
   cmd_type push_data, pop_data;

   zbf_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_push    (push),
      .q_data    (push_data),
      .q_full    (full)
   );

   zbf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .data_in  (push_data),
      .full     (full),
      .pop      (pop),
      .data_out (pop_data),
      .empty    (empty)
   );

   zbf_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (empty),
      .q_data  (pop_data),
      .q_pop   (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

// ===== src/zbf_front.sv =====
module zbf_front #(
   parameter int MAX_WIDTH  = zbf_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = zbf_pkg::DEF_MAX_HEIGHT
) (
   input  logic             clock,
   input  logic             reset,
   zbf_req_if.sink          req_bus,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [8:0]       csr_wdata,
   output logic             q_push,
   output zbf_pkg::cmd_type q_data,
   input  logic             q_full
);
   import zbf_pkg::*;

   localparam int RW = $clog2(MAX_HEIGHT);

   front_state_type state_ff, state_in;
   logic [8:0]  width_ff;
   logic [8:0]  height_ff;
   logic        mode_ff;

   cmd_type                cmd_ff;
   logic [DIV_W-1:0]       dvd_ff;
   logic [DEN_W-1:0]       rem_ff;
   logic [DEN_W-1:0]       den_ff;
   logic                   neg_ff;
   logic [DIV_CNT_W-1:0]   cnt_ff;

   logic [DIM_W-1:0]   w, h;
   logic signed [16:0] y_s, x1_s, x2_s, w_s, h_s, den_s;
   logic signed [24:0] a_s, b_s, diff_s;
   logic               reject, accept;
   cmd_type            cmd_in;
   logic [DEN_W:0]     shifted;
   logic               q_bit;
   logic [DEN_W-1:0]   rem_in;
   logic [31:0]        q_ext;

   assign accept = req_bus.valid & req_bus.ready;

   always_comb begin
      w      = clamp_dim(width_ff, MAX_WIDTH);
      h      = clamp_dim(height_ff, MAX_HEIGHT);
      y_s    = {req_bus.row[15], req_bus.row};
      x1_s   = {req_bus.left_col[15], req_bus.left_col};
      x2_s   = {req_bus.right_col[15], req_bus.right_col};
      w_s    = $signed({4'b0, w});
      h_s    = $signed({4'b0, h});
      den_s  = x2_s - x1_s;
      a_s    = $signed({req_bus.left_depth[31], req_bus.left_depth[31:DEPTH_SHIFT]});
      b_s    = $signed({req_bus.right_depth[31], req_bus.right_depth[31:DEPTH_SHIFT]});
      diff_s = b_s - a_s;
      reject = (y_s < 0) || (x1_s == x2_s) || (y_s >= h_s) || (x1_s >= w_s) || (x2_s < 0);

      cmd_in      = '0;
      cmd_in.w    = w;
      cmd_in.h    = h;
      cmd_in.d1   = {{DEPTH_SHIFT{req_bus.left_depth[31]}}, req_bus.left_depth[31:DEPTH_SHIFT]};
      cmd_in.d2   = {{DEPTH_SHIFT{req_bus.right_depth[31]}},
                     req_bus.right_depth[31:DEPTH_SHIFT]};
      cmd_in.adv  = (x1_s < 0) ? 16'(-x1_s) : 16'd0;
      cmd_in.x_lo = (x1_s < 0) ? '0 : req_bus.left_col[COORD_W-1:0];
      cmd_in.x_hi = (x2_s >= w_s) ? COORD_W'(w - DIM_W'(1)) : req_bus.right_col[COORD_W-1:0];
      cmd_in.color = mode_ff ? req_bus.fill_color : {8'd0, req_bus.fill_color[7:0]};
      case (req_bus.action)
         ACT_DRAW: begin
            cmd_in.op   = reject ? CMD_REJECT : CMD_SPAN;
            cmd_in.base = ADDR_W'(req_bus.row[RW-1:0]) * ADDR_W'(MAX_WIDTH);
         end
         ACT_FRAME: cmd_in.op = CMD_FRAME;
         ACT_READ: begin
            // Reads outside the store answer zeros, handled as a no-op.
            if ((DIM_W'(req_bus.read_col) < DIM_W'(MAX_WIDTH)) &&
                (DIM_W'(req_bus.read_row) < DIM_W'(MAX_HEIGHT))) begin
               cmd_in.op = CMD_READ;
            end else begin
               cmd_in.op = CMD_NOP;
            end
            cmd_in.base = ADDR_W'(req_bus.read_row) * ADDR_W'(MAX_WIDTH)
                        + ADDR_W'(req_bus.read_col);
         end
         default: cmd_in.op = CMD_NOP;
      endcase
   end

   // Restoring divider on magnitudes, one quotient bit per cycle.
   always_comb begin
      shifted = {rem_ff, dvd_ff[DIV_W-1]};
      q_bit   = shifted >= {1'b0, den_ff};
      rem_in  = q_bit ? DEN_W'(shifted - {1'b0, den_ff}) : DEN_W'(shifted);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               state_in = (cmd_in.op == CMD_SPAN) ? F_DIV : F_PUSH;
            end
         end
         F_DIV: begin
            if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      req_bus.ready = (state_ff == F_IDLE);
      q_push        = (state_ff == F_PUSH) && !q_full;
      q_ext         = 32'(dvd_ff);
      q_data        = cmd_ff;
      q_data.step   = neg_ff ? -q_ext : q_ext;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= F_IDLE;
         width_ff  <= 9'd256;
         height_ff <= 9'd256;
         mode_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_WIDTH:  width_ff  <= csr_wdata;
               CSR_HEIGHT: height_ff <= csr_wdata;
               CSR_MODE:   mode_ff   <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == F_IDLE && accept) begin
         cmd_ff <= cmd_in;
         dvd_ff <= diff_s[24] ? DIV_W'(-diff_s) : DIV_W'(diff_s);
         den_ff <= den_s[16] ? DEN_W'(-den_s) : DEN_W'(den_s);
         neg_ff <= diff_s[24] ^ den_s[16];
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (state_ff == F_DIV) begin
         dvd_ff <= {dvd_ff[DIV_W-2:0], q_bit};
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + DIV_CNT_W'(1);
      end
   end

endmodule

// ===== src/zbf_queue.sv =====
module zbf_queue #(
   parameter int DEPTH = zbf_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  zbf_pkg::cmd_type data_in,
   output logic             full,
   input  logic             pop,
   output zbf_pkg::cmd_type data_out,
   output logic             empty
);
   import zbf_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type         slot_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]   count_ff;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign data_out = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= data_in;
      end
   end

endmodule

// ===== src/zbf_back.sv =====
module zbf_back #(
   parameter int MAX_WIDTH  = zbf_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = zbf_pkg::DEF_MAX_HEIGHT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  zbf_pkg::cmd_type q_data,
   output logic             q_pop,
   zbf_rsp_if.source        rsp_bus
);
   import zbf_pkg::*;

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);

   back_state_type state_ff, state_in;
   cmd_type        cmd_ff;
   logic [31:0]    offset_ff, max_ff;
   logic [31:0]    z1_ff, z2_ff, prod_ff, z_ff, m1;
   logic [CW-1:0]  x_ff, x_hi;
   logic           p_valid_ff;
   logic [AW-1:0]  p_addr_ff;
   logic [31:0]    p_z_ff;
   logic [8:0]     cnt_ff;
   logic           rej_ff;
   logic [15:0]    rcolor_ff;
   logic [31:0]    rdepth_ff;
   logic [CW-1:0]  clr_col_ff;
   logic [RW-1:0]  clr_row_ff;
   logic [AW-1:0]  clr_base_ff;
   logic           clr_last, go;

   logic [31:0]    depth_mem [DEPTH];
   logic [15:0]    color_mem [DEPTH];
   logic [31:0]    depth_rd_ff;
   logic [15:0]    color_rd_ff;
   logic [AW-1:0]  rd_addr, wr_addr;
   logic [31:0]    depth_wd;
   logic           depth_we, color_we, hit;

   assign x_hi     = cmd_ff.x_hi[CW-1:0];
   assign clr_last = (DIM_W'(clr_row_ff) == cmd_ff.h - DIM_W'(1)) &&
                     (DIM_W'(clr_col_ff) == cmd_ff.w - DIM_W'(1));
   assign go       = !rsp_bus.valid || rsp_bus.ready;
   assign hit      = p_valid_ff && (p_z_ff > depth_rd_ff);
   assign m1       = (z1_ff > max_ff) ? z1_ff : max_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               case (q_data.op)
                  CMD_SPAN:  state_in = B_SETUP;
                  CMD_FRAME: state_in = B_CLEAR;
                  CMD_READ:  state_in = B_READ;
                  default:   state_in = B_RESULT;
               endcase
            end
         end
         B_SETUP: state_in = B_PREP;
         B_PREP:  state_in = (cmd_ff.x_lo <= cmd_ff.x_hi) ? B_SPAN : B_RESULT;
         B_SPAN:  state_in = (x_ff == x_hi) ? B_DRAIN : B_SPAN;
         B_DRAIN: state_in = B_RESULT;
         B_CLEAR: begin
            if (offset_ff != 32'd0 || clr_last) begin
               state_in = B_RESULT;
            end
         end
         B_READ:   state_in = B_RDATA;
         B_RDATA:  state_in = B_RESULT;
         B_RESULT: state_in = go ? B_IDLE : B_RESULT;
         default:  state_in = B_IDLE;
      endcase
   end

   always_comb begin
      q_pop    = (state_ff == B_IDLE) && !q_empty;
      rd_addr  = (state_ff == B_SPAN) ? cmd_ff.base[AW-1:0] + AW'(x_ff) : cmd_ff.base[AW-1:0];
      wr_addr  = p_addr_ff;
      depth_wd = p_z_ff;
      depth_we = hit;
      color_we = hit;
      if (state_ff == B_CLEAR && offset_ff == 32'd0) begin
         wr_addr  = clr_base_ff + AW'(clr_col_ff);
         depth_wd = 32'd0;
         depth_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (depth_we) begin
         depth_mem[wr_addr] <= depth_wd;
      end
      depth_rd_ff <= depth_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (color_we) begin
         color_mem[wr_addr] <= cmd_ff.color;
      end
      color_rd_ff <= color_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         offset_ff     <= '0;
         max_ff        <= '0;
         p_valid_ff    <= 1'b0;
         rsp_bus.valid <= 1'b0;
      end else begin
         state_ff   <= state_in;
         p_valid_ff <= (state_ff == B_SPAN);
         if (state_ff == B_PREP) begin
            max_ff <= (z2_ff > m1) ? z2_ff : m1;
         end
         if (state_ff == B_CLEAR && (offset_ff != 32'd0 || clr_last)) begin
            offset_ff <= max_ff;
         end
         if (state_ff == B_RESULT && go) begin
            rsp_bus.valid <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_bus.valid <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff      <= q_data;
         cnt_ff      <= '0;
         rej_ff      <= (q_data.op == CMD_REJECT);
         rcolor_ff   <= '0;
         rdepth_ff   <= '0;
         clr_col_ff  <= '0;
         clr_row_ff  <= '0;
         clr_base_ff <= '0;
      end
      if (state_ff == B_SETUP) begin
         z1_ff   <= cmd_ff.d1 + offset_ff;
         z2_ff   <= cmd_ff.d2 + offset_ff;
         prod_ff <= 32'(cmd_ff.step * {16'd0, cmd_ff.adv});
      end
      if (state_ff == B_PREP) begin
         z_ff <= z1_ff + prod_ff;
         x_ff <= cmd_ff.x_lo[CW-1:0];
      end
      if (state_ff == B_SPAN) begin
         x_ff      <= x_ff + CW'(1);
         z_ff      <= z_ff + cmd_ff.step;
         p_addr_ff <= rd_addr;
         p_z_ff    <= z_ff;
      end
      if (hit && cnt_ff != 9'd511) begin
         cnt_ff <= cnt_ff + 9'd1;
      end
      if (state_ff == B_CLEAR && offset_ff == 32'd0 && !clr_last) begin
         if (DIM_W'(clr_col_ff) == cmd_ff.w - DIM_W'(1)) begin
            clr_col_ff  <= '0;
            clr_row_ff  <= clr_row_ff + RW'(1);
            clr_base_ff <= clr_base_ff + AW'(MAX_WIDTH);
         end else begin
            clr_col_ff <= clr_col_ff + CW'(1);
         end
      end
      if (state_ff == B_RDATA) begin
         rcolor_ff <= color_rd_ff;
         rdepth_ff <= depth_rd_ff;
      end
      if (state_ff == B_RESULT && go) begin
         rsp_bus.span_rejected  <= rej_ff;
         rsp_bus.pixels_written <= cnt_ff;
         rsp_bus.read_color     <= rcolor_ff;
         rsp_bus.read_depth     <= rdepth_ff;
      end
   end

endmodule
